// File: rtl/gts_pkg.sv
package gts_pkg;

  typedef struct packed {
    logic        op;
    logic [31:0] time_draw;
    logic [31:0] choice_draw;
  } step_in_t;

  typedef struct packed {
    logic [31:0] sim_time;
    logic [15:0] count_a;
    logic [15:0] count_b;
    logic [1:0]  event_res;
    logic        finished;
  } step_out_t;

  localparam logic [2:0] REG_INIT_A = 3'd0;
  localparam logic [2:0] REG_INIT_B = 3'd1;
  localparam logic [2:0] REG_RATE_AB = 3'd2;
  localparam logic [2:0] REG_RATE_BA = 3'd3;
  localparam logic [2:0] REG_STOP = 3'd4;

  localparam logic [1:0] EV_A_TO_B = 2'd0;
  localparam logic [1:0] EV_B_TO_A = 2'd1;
  localparam logic [1:0] EV_NONE = 2'd2;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int LOG_FRAC = 24;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture item, compute propensities
    logic restart;   // reload counts
    logic halt;      // end run without advancing
    logic norm;      // normalise draw (one shift step)
    logic sq;        // one squaring step
    logic lnmul;     // latch log2 term for the ln 2 product
    logic div_init;  // start division
    logic div_step;  // one quotient bit
    logic advance;   // add time, test stop
    logic choose;    // choice product
    logic fire;      // move a molecule
    logic publish;   // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic run_over;
    logic end_now;
    logic norm_done;
    logic past_stop;
  } dp_stat_t;

endpackage

// File: rtl/gillespie_two_species_step.sv
// Channel  | handshake                 | payload
// step in  | in_valid / in_ready       | in_data  (step_in_t)
// result   | out_valid / out_ready     | out_data (step_out_t)
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
// One item at a time. A step runs decode, draw normalisation, 24 squaring steps of the
// log unit, the ln 2 term, division setup, then one quotient bit per cycle up to
// 32 + TIME_FRAC_BITS bits, time advance, and choice and fire unless past stop_time;
// then publish. Restart and end-of-run items go from decode straight to publish.
// Reset is synchronous; counts load 10000 and 10, time zero.
// A stalled result holds the input side; the next transfer can come in the cycle after it.
module gillespie_two_species_step #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gts_pkg::step_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gts_pkg::step_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gts_pkg::*;

  logic [14:0] init_a, init_b;
  logic [15:0] rate_ab, rate_ba;
  logic [31:0] stop_time;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_a <= 15'd10000;
      init_b <= 15'd10;
      rate_ab <= 16'd6554;
      rate_ba <= 16'd655;
      stop_time <= 32'd3276800;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INIT_A:  init_a <= cfg_data[14:0];
        REG_INIT_B:  init_b <= cfg_data[14:0];
        REG_RATE_AB: rate_ab <= cfg_data[15:0];
        REG_RATE_BA: rate_ba <= cfg_data[15:0];
        REG_STOP:    stop_time <= cfg_data;
        default: ;
      endcase
    end
  end

  gts_ctrl #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  gts_datapath #(.COUNT_BITS(COUNT_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .item(in_data),
    .init_a(init_a), .init_b(init_b), .rate_ab(rate_ab), .rate_ba(rate_ba),
    .stop_time(stop_time), .result(out_data)
  );

endmodule

// File: rtl/gts_datapath.sv
module gts_datapath #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gts_pkg::dp_cmd_t  cmd,
  output gts_pkg::dp_stat_t stat,
  input  gts_pkg::step_in_t item,
  input  logic [14:0]       init_a,
  input  logic [14:0]       init_b,
  input  logic [15:0]       rate_ab,
  input  logic [15:0]       rate_ba,
  input  logic [31:0]       stop_time,
  output gts_pkg::step_out_t result
);
  import gts_pkg::*;

  localparam int PW = COUNT_BITS + 16;
  localparam int TW = PW + 1;
  localparam int LW = 32 + TIME_FRAC_BITS;   // shifted logarithm width
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] pop_a, pop_b;
  logic [31:0] time_now;
  logic        run_over;
  logic [31:0] rdraw, cdraw;
  logic        op_q;
  logic [PW-1:0] pa, pb;
  logic [TW-1:0] total;
  logic [32:0] m;
  logic [5:0]  p;
  logic [LOG_FRAC-1:0] f;
  logic [31:0] nl2;
  logic [LW-1:0] dividend;
  logic [TW-1:0] rem;
  logic [LW-1:0] quo;
  logic        ev_ab;
  logic [1:0]  ev;

  logic [65:0] msq;
  logic [63:0] lnprod;
  logic [TW:0] rem_sh;
  logic [TW+31:0] chprod;
  logic [32:0] tsum;
  logic [31:0] tsat;
  logic [PW+31:0] pa_sh;
  logic [COUNT_BITS-1:0] sat_a, sat_b;

  assign msq = {33'd0, m} * {33'd0, m};
  assign lnprod = {32'd0, nl2} * {32'd0, LN2_Q32};
  assign rem_sh = {rem, dividend[LW-1]};
  assign chprod = {32'd0, total} * {{TW{1'b0}}, cdraw};
  assign tsum = {1'b0, time_now} + {1'b0, quo[31:0]};
  // saturate the new time at the top of the range
  assign tsat = ((quo[LW-1:32] != '0) || tsum[32]) ? 32'hFFFF_FFFF : tsum[31:0];
  assign pa_sh = {pa, 32'd0};

  always_comb begin
    if (COUNT_BITS > 15) sat_a = COUNT_BITS'(init_a);
    else sat_a = (init_a > 15'(CMAX)) ? CMAX : COUNT_BITS'(init_a);
    if (COUNT_BITS > 15) sat_b = COUNT_BITS'(init_b);
    else sat_b = (init_b > 15'(CMAX)) ? CMAX : COUNT_BITS'(init_b);
  end

  assign stat.op = op_q;
  assign stat.run_over = run_over;
  assign stat.end_now = (time_now >= stop_time) || (pop_a == '0) || (pop_b == '0) ||
                        (pa == '0) || (pb == '0);
  assign stat.norm_done = m[31] || (p == 6'd0);
  assign stat.past_stop = tsat > stop_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_a <= 16'd10000 > 17'(CMAX) ? CMAX : COUNT_BITS'(10000);
      pop_b <= COUNT_BITS'(10);
      time_now <= '0;
      run_over <= 1'b0;
      ev <= EV_NONE;
    end else begin
      if (cmd.load) begin
        op_q <= item.op;
        rdraw <= item.time_draw;
        cdraw <= item.choice_draw;
        pa <= PW'(pop_a) * PW'(rate_ab);
        pb <= PW'(pop_b) * PW'(rate_ba);
        ev <= EV_NONE;
        m <= {1'b0, item.time_draw};
        p <= 6'd31;
        f <= '0;
      end
      if (cmd.restart) begin
        pop_a <= sat_a;
        pop_b <= sat_b;
        time_now <= '0;
        run_over <= 1'b0;
      end
      if (cmd.halt) run_over <= 1'b1;
      if (cmd.norm) begin
        total <= TW'({1'b0, pa} + {1'b0, pb});
        if (!(m[31] || p == 6'd0)) begin
          m <= {m[31:0], 1'b0};
          p <= p - 6'd1;
        end
      end
      if (cmd.sq) begin
        if (msq[63]) begin
          m <= msq[64:32];
          f <= {f[LOG_FRAC-2:0], 1'b1};
        end else begin
          m <= msq[63:31];
          f <= {f[LOG_FRAC-2:0], 1'b0};
        end
      end
      if (cmd.lnmul) nl2 <= ({p == 6'd0 ? 8'd32 : 8'(6'd32 - p), 24'd0}) - {8'd0, f};
      if (cmd.div_init) begin
        dividend <= LW'((rdraw == '0) ? 32'd0 : lnprod[63:32]) << (TIME_FRAC_BITS - 8);
        rem <= '0;
        quo <= '0;
      end
      if (cmd.div_step) begin
        if (rem_sh >= {1'b0, total}) begin
          rem <= TW'(rem_sh - {1'b0, total});
          quo <= {quo[LW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[TW-1:0];
          quo <= {quo[LW-2:0], 1'b0};
        end
        dividend <= {dividend[LW-2:0], 1'b0};
      end
      if (cmd.advance) begin
        time_now <= tsat;
        if (tsat > stop_time) run_over <= 1'b1;
      end
      if (cmd.choose) ev_ab <= chprod < pa_sh;
      if (cmd.fire) begin
        if (ev_ab) begin
          pop_a <= pop_a - 1'b1;
          pop_b <= (pop_b == CMAX) ? CMAX : pop_b + 1'b1;
          ev <= EV_A_TO_B;
        end else begin
          pop_b <= pop_b - 1'b1;
          pop_a <= (pop_a == CMAX) ? CMAX : pop_a + 1'b1;
          ev <= EV_B_TO_A;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.sim_time <= time_now;
      result.count_a <= 16'(pop_a);
      result.count_b <= 16'(pop_b);
      result.event_res <= ev;
      result.finished <= run_over;
    end
  end

endmodule

// File: rtl/gts_ctrl.sv
module gts_ctrl #(
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gts_pkg::dp_cmd_t  cmd,
  input  gts_pkg::dp_stat_t stat
);
  import gts_pkg::*;

  localparam int DIVN = 32 + TIME_FRAC_BITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_NORM  = 11'b00000000100,
    S_SQ    = 11'b00000001000,
    S_LN    = 11'b00000010000,
    S_DINIT = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_ADV   = 11'b00010000000,
    S_CHO   = 11'b00100000000,
    S_FIRE  = 11'b01000000000,
    S_PUB   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [5:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    cnt_next = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op) begin
          cmd.restart = 1'b1;
          state_next = S_PUB;
        end else if (stat.run_over) begin
          state_next = S_PUB;
        end else if (stat.end_now) begin
          cmd.halt = 1'b1;
          state_next = S_PUB;
        end else begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        cnt_next = '0;
        if (stat.norm_done) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(LOG_FRAC - 1)) state_next = S_LN;
      end
      S_LN: begin
        cmd.lnmul = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(DIVN - 1)) state_next = S_ADV;
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next = stat.past_stop ? S_PUB : S_CHO;
      end
      S_CHO: begin
        cmd.choose = 1'b1;
        state_next = S_FIRE;
      end
      S_FIRE: begin
        cmd.fire = 1'b1;
        state_next = S_PUB;
      end
      S_PUB: begin
        cmd.publish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (state == S_PUB) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
